### design/int8_vector_rounded_average_defines.svh
// Assertion macros used by the checker file.
`ifndef INT8_VECTOR_ROUNDED_AVERAGE_DEFINES_SVH
`define INT8_VECTOR_ROUNDED_AVERAGE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IVRA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ivra assertion failed");

// Next-cycle implication, disabled during reset.
`define IVRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ivra assertion failed");

`endif

### design/ivra_pkg.sv
`timescale 1ns / 1ps

package ivra_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_SOURCES_DEF  = 16;
  localparam int COUNTER_BITS_DEF = 24;

  // Fixed field widths
  localparam int VALUE_W        = 8;
  localparam int SOURCE_COUNT_W = 5;
  localparam int STAT_W         = 24;
  localparam int PEAK_W         = 7;

  localparam logic [SOURCE_COUNT_W-1:0] SOURCE_COUNT_RST = 5'd2;

  // Clamp limits of the blended value
  localparam logic [PEAK_W-1:0] BLEND_MAG_MAX = 7'd127;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIVIDE,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  // Statistics update request from the sequencer
  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] blended;
    logic signed [VALUE_W-1:0] first;
  } stats_upd_t;

endpackage

### design/ivra_if.sv
`timescale 1ns / 1ps

// Source item channel
interface ivra_src_if import ivra_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] source_value;

  modport source (output valid, output source_value, input ready);
  modport sink   (input valid, input source_value, output ready);
endinterface

// Result item channel
interface ivra_res_if import ivra_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] blended_value;
  logic [STAT_W-1:0]         nonzero_total;
  logic [PEAK_W-1:0]         largest_magnitude;
  logic [STAT_W-1:0]         changed_total;

  modport source (output valid, output blended_value, output nonzero_total,
                  output largest_magnitude, output changed_total, input ready);
  modport sink   (input valid, input blended_value, input nonzero_total,
                  input largest_magnitude, input changed_total, output ready);
endinterface

// Configuration write channel
interface ivra_cfg_if import ivra_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [SOURCE_COUNT_W-1:0] source_count;

  modport source (output valid, output source_count, input ready);
  modport sink   (input valid, input source_count, output ready);
endinterface

### design/ivra_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module ivra_div #(
  parameter int DIVIDEND_W = 12,
  parameter int DIVISOR_W  = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] acc;
  logic [DIVISOR_W-1:0]  rem;
  logic [STEP_W-1:0]     steps;
  logic                  running;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    trial_sub;
  logic                  fits;

  // Shift in the next dividend bit and try the subtract
  assign trial     = {rem, acc[DIVIDEND_W-1]};
  assign trial_sub = trial - {1'b0, divisor};
  assign fits      = (trial >= {1'b0, divisor});

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= STEP_W'(DIVIDEND_W);
      end else if (running) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Quotient bits replace dividend bits from the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
    end else if (running) begin
      acc <= {acc[DIVIDEND_W-2:0], fits};
      rem <= fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign quotient = acc;

endmodule

### design/ivra_stats.sv
`timescale 1ns / 1ps

// Running statistics over emitted blended values.
module ivra_stats import ivra_pkg::*; #(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  stats_upd_t        upd,
  output logic [STAT_W-1:0] nonzero_total,
  output logic [PEAK_W-1:0] largest_magnitude,
  output logic [STAT_W-1:0] changed_total
);

  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

  logic [COUNTER_BITS-1:0] nonzero_counter;
  logic [COUNTER_BITS-1:0] changed_counter;
  logic [PEAK_W-1:0]       peak_magnitude;
  logic [VALUE_W-1:0]      neg_blended;
  logic [PEAK_W-1:0]       mag;

  // Magnitude of the blended value (never -128)
  assign neg_blended = -upd.blended;
  assign mag = upd.blended[VALUE_W-1] ? neg_blended[PEAK_W-1:0]
                                      : upd.blended[PEAK_W-1:0];

  // Saturating counters and peak tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      nonzero_counter <= '0;
      changed_counter <= '0;
      peak_magnitude  <= '0;
    end else if (upd.valid) begin
      if ((upd.blended != upd.first) && (changed_counter != CNT_MAX)) begin
        changed_counter <= changed_counter + 1'b1;
      end
      if (upd.blended != '0) begin
        if (nonzero_counter != CNT_MAX) begin
          nonzero_counter <= nonzero_counter + 1'b1;
        end
        if (mag > peak_magnitude) begin
          peak_magnitude <= mag;
        end
      end
    end
  end

  assign nonzero_total     = STAT_W'(nonzero_counter);
  assign changed_total     = STAT_W'(changed_counter);
  assign largest_magnitude = peak_magnitude;

endmodule

### design/int8_vector_rounded_average.sv
// Rounded-mean blender for signed 8-bit weights. Every source_count source
// items (count 0 acts as 1, counts above MAX_SOURCES act as MAX_SOURCES) form
// one element; the closing item yields one result: the mean rounded half away
// from zero and clamped to -127..127, plus saturating counts of nonzero
// results and of results unlike the element's first item, and the largest
// magnitude so far. A non-closing item only adds to the sum. A closing item
// passes through PREP, DIVIDE (one-bit-per-cycle divider), UPDATE and EMIT;
// the block takes no item meanwhile. A finished result sits in an output
// register, so the next element's items are taken while it waits.
`timescale 1ns / 1ps

module int8_vector_rounded_average import ivra_pkg::*; #(
  parameter int MAX_SOURCES  = MAX_SOURCES_DEF,
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ivra_src_if.sink  src,
  ivra_res_if.source res,
  ivra_cfg_if.sink  cfg
);

  localparam int POS_W = $clog2(MAX_SOURCES + 1);
  localparam int SUM_W = $clog2(128 * MAX_SOURCES) + 1;
  localparam int MAG_W = $clog2(128 * MAX_SOURCES + MAX_SOURCES / 2 + 1);

  state_t state;
  state_t state_next;

  logic [SOURCE_COUNT_W-1:0] source_count;
  logic [POS_W-1:0]         eff_count;
  logic [POS_W-1:0]         source_position;
  logic [POS_W-1:0]         pos_inc;
  logic signed [SUM_W-1:0]  running_sum;
  logic signed [SUM_W-1:0]  sum_add;
  logic signed [VALUE_W-1:0] first_source_value;
  logic                     sum_neg;
  logic [SUM_W-1:0]         abs_sum;
  logic [MAG_W-1:0]         dividend;
  logic                     in_accept;
  logic                     closing;

  logic                     div_start;
  logic                     div_done;
  logic [MAG_W-1:0]         quotient;
  logic [PEAK_W-1:0]        q_mag;
  logic signed [VALUE_W-1:0] q_value;
  logic signed [VALUE_W-1:0] blended_q;

  logic                     stats_valid;
  stats_upd_t               upd;
  logic [STAT_W-1:0]        st_nonzero;
  logic [PEAK_W-1:0]        st_peak;
  logic [STAT_W-1:0]        st_changed;

  logic                     out_valid;
  logic                     out_load;
  logic signed [VALUE_W-1:0] out_blended;
  logic [STAT_W-1:0]        out_nonzero;
  logic [PEAK_W-1:0]        out_peak;
  logic [STAT_W-1:0]        out_changed;

  // Configuration register, always writable
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_count <= SOURCE_COUNT_RST;
    end else if (cfg.valid) begin
      source_count <= cfg.source_count;
    end
  end

  // Effective count: zero acts as one, clamp to MAX_SOURCES
  always_comb begin
    if (source_count == '0) begin
      eff_count = POS_W'(1);
    end else if (32'(source_count) > 32'(MAX_SOURCES)) begin
      eff_count = POS_W'(MAX_SOURCES);
    end else begin
      eff_count = POS_W'(source_count);
    end
  end

  // Accumulation
  assign in_accept = src.valid && src.ready;
  assign pos_inc   = source_position + 1'b1;
  assign sum_add   = running_sum + SUM_W'(src.source_value);
  assign closing   = (pos_inc >= eff_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum     <= '0;
      source_position <= '0;
    end else if (in_accept) begin
      running_sum     <= sum_add;
      source_position <= closing ? '0 : pos_inc;
    end else if (state == ST_PREP) begin
      running_sum <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (source_position == '0)) begin
      first_source_value <= src.source_value;
    end
  end

  // Rounding bias added to the magnitude before the divide
  assign abs_sum  = running_sum[SUM_W-1] ? (~running_sum + 1'b1) : running_sum;
  assign dividend = MAG_W'(abs_sum) + MAG_W'(eff_count >> 1);

  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      sum_neg <= running_sum[SUM_W-1];
    end
  end

  ivra_div #(
    .DIVIDEND_W (MAG_W),
    .DIVISOR_W  (POS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (eff_count),
    .done     (div_done),
    .quotient (quotient)
  );

  // Clamp and restore sign
  assign q_mag   = (quotient > MAG_W'(BLEND_MAG_MAX)) ? BLEND_MAG_MAX : quotient[PEAK_W-1:0];
  assign q_value = sum_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      blended_q <= q_value;
    end
  end

  assign upd = '{valid: stats_valid, blended: q_value, first: first_source_value};

  ivra_stats #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_stats (
    .clk               (clk),
    .rst               (rst),
    .upd               (upd),
    .nonzero_total     (st_nonzero),
    .largest_magnitude (st_peak),
    .changed_total     (st_changed)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept && closing) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP:   state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    src.ready   = 1'b0;
    div_start   = 1'b0;
    stats_valid = 1'b0;
    out_load    = 1'b0;
    case (state)
      ST_IDLE:   src.ready   = 1'b1;
      ST_PREP:   div_start   = 1'b1;
      ST_DIVIDE: ;
      ST_UPDATE: stats_valid = 1'b1;
      ST_EMIT:   out_load    = !out_valid || res.ready;
      default:   ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_blended <= blended_q;
      out_nonzero <= st_nonzero;
      out_peak    <= st_peak;
      out_changed <= st_changed;
    end
  end

  assign res.valid             = out_valid;
  assign res.blended_value     = out_blended;
  assign res.nonzero_total     = out_nonzero;
  assign res.largest_magnitude = out_peak;
  assign res.changed_total     = out_changed;

endmodule

### design/ivra_checker.sv
`timescale 1ns / 1ps
`include "int8_vector_rounded_average_defines.svh"

// Port-level checks on the result channel.
module ivra_checker import ivra_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic [VALUE_W-1:0] blended_value,
  input logic [STAT_W-1:0] nonzero_total,
  input logic [PEAK_W-1:0] largest_magnitude,
  input logic [STAT_W-1:0] changed_total
);

  logic [VALUE_W+2*STAT_W+PEAK_W-1:0] res_payload;
  logic                               res_stall;
  logic                               res_accept;
  logic                               res_nonzero;
  logic                               stats_nonzero;
  logic [PEAK_W-1:0]                  peak_seen;
  logic                               peak_kept;

  // Helper terms for the checks below
  assign res_payload   = {blended_value, nonzero_total, largest_magnitude, changed_total};
  assign res_stall     = res_valid && !res_ready;
  assign res_accept    = res_valid && res_ready;
  assign res_nonzero   = res_valid && (blended_value != '0);
  assign stats_nonzero = (nonzero_total != '0) && (largest_magnitude != '0);
  assign peak_kept     = !res_valid || (largest_magnitude >= peak_seen);

  // Peak shown at the previous edge
  always_ff @(posedge clk) begin
    peak_seen <= largest_magnitude;
  end

  // A stalled item holds
  `IVRA_ASSERT_NEXT(a_res_hold, clk, rst, res_stall, res_valid && $stable(res_payload))

  // Clamp keeps the most negative code out
  `IVRA_ASSERT_NOW(a_no_min_code, clk, rst, res_valid, blended_value != 8'h80)

  // A nonzero result must show up in the count and the peak
  `IVRA_ASSERT_NOW(a_nonzero_seen, clk, rst, res_nonzero, stats_nonzero)

  // Peak never drops from one item to the next
  `IVRA_ASSERT_NEXT(a_peak_mono, clk, rst, res_accept, peak_kept)

endmodule

bind int8_vector_rounded_average ivra_checker u_ivra_checker (
  .clk               (clk),
  .rst               (rst),
  .res_valid         (res.valid),
  .res_ready         (res.ready),
  .blended_value     (res.blended_value),
  .nonzero_total     (res.nonzero_total),
  .largest_magnitude (res.largest_magnitude),
  .changed_total     (res.changed_total)
);
